@@ hdl/epcal_pkg.sv @@
// Shared types and constants of the epoch to calendar date converter.
// Holds the word layouts of both channels, the day-cycle divisors with their
// reciprocals, and the cumulative month tables. Depends on nothing.
package epcal_pkg;

	typedef struct packed {
		logic signed [38:0] epoch_seconds;
		logic               use_local;
	} time_word_t;

	typedef struct packed {
		logic [13:0] calendar_year;
		logic [8:0]  day_of_year;
		logic [3:0]  month_index;
		logic [4:0]  day_of_month;
		logic [2:0]  weekday;
		logic [4:0]  hour_of_day;
		logic [5:0]  minute_of_hour;
		logic [5:0]  second_of_minute;
		logic        range_error;
	} date_word_t;

	localparam logic signed [39:0] SECS_1601_TO_1970 = 40'sd11644473600;
	localparam logic signed [39:0] SECS_LAST_1970    = 40'sd253402300799;

	// 86400 = 675 << 7
	localparam logic [9:0]  DAY_ODD    = 10'd675;
	localparam logic [31:0] RCP_DAY    = 32'(((64'd1 << 41) + 64'd674) / 64'd675);

	localparam logic [17:0] DAYS_400Y  = 18'd146097;
	localparam logic [22:0] RCP_400Y   = 23'(((64'd1 << 40) + 64'd146096) / 64'd146097);
	localparam logic [15:0] DAYS_100Y  = 16'd36524;
	localparam logic [18:0] RCP_100Y   = 19'(((64'd1 << 34) + 64'd36523) / 64'd36524);
	localparam logic [10:0] DAYS_4Y    = 11'd1461;
	localparam logic [16:0] RCP_4Y     = 17'(((64'd1 << 27) + 64'd1460) / 64'd1461);
	localparam logic [8:0]  DAYS_1Y    = 9'd365;
	localparam logic [11:0] RCP_1Y     = 12'(((64'd1 << 20) + 64'd364) / 64'd365);

	localparam logic [2:0]  WEEK_LEN   = 3'd7;
	localparam logic [22:0] RCP_WEEK   = 23'(((64'd1 << 25) + 64'd6) / 64'd7);
	localparam logic [5:0]  SIXTY      = 6'd60;
	localparam logic [17:0] RCP_60_SEC = 18'(((64'd1 << 23) + 64'd59) / 64'd60);
	localparam logic [11:0] RCP_60_MIN = 12'(((64'd1 << 17) + 64'd59) / 64'd60);

	localparam logic [2:0]  CENT_MAX   = 3'd3;
	localparam logic [5:0]  QUAD_MAX   = 6'd24;
	localparam logic [2:0]  YEAR_MAX   = 3'd3;
	localparam logic [13:0] YEAR_BASE  = 14'd1601;

	localparam logic [8:0] CUM_DAYS_COMMON [13] =
		'{9'd0, 9'd31, 9'd59, 9'd90, 9'd120, 9'd151, 9'd181,
		  9'd212, 9'd243, 9'd273, 9'd304, 9'd334, 9'd365};
	localparam logic [8:0] CUM_DAYS_LEAP [13] =
		'{9'd0, 9'd31, 9'd60, 9'd91, 9'd121, 9'd152, 9'd182,
		  9'd213, 9'd244, 9'd274, 9'd305, 9'd335, 9'd366};

	function automatic logic [8:0] cum_days(input logic leap, input logic [3:0] idx);
		logic [8:0] res;
		res = 9'd0;
		if (idx <= 4'd12) begin
			res = leap ? CUM_DAYS_LEAP[idx] : CUM_DAYS_COMMON[idx];
		end
		return res;
	endfunction

endpackage

@@ hdl/epoch_to_calendar_date_core.sv @@
// Top level of the epoch to calendar date converter: a 13-stage pipeline with
// an output register and a one-word skid stage. Uses epcal_pkg.
// Throughput: one word per cycle while time_stall is low; each division is a reciprocal multiply stage
// followed by a remainder stage, and the output skid stage sets the stall path.
// Reset: arst_n clears all valid bits and the zone offset to zero.
module epoch_to_calendar_date_core import epcal_pkg::*; (
	input  logic                clk,
	input  logic                arst_n,
	input  logic                time_valid,
	output logic                time_stall,
	input  time_word_t          time_word,
	output logic                date_valid,
	input  logic                date_stall,
	output date_word_t          date_word,
	input  logic                zone_valid,
	output logic                zone_ready,
	input  logic signed [17:0]  zone_offset_seconds
);

	typedef struct packed {
		logic [4:0] hour;
		logic [5:0] minute;
		logic [5:0] second;
		logic [2:0] wday;
	} tod_t;

	logic signed [17:0] zone_offset_q;
	logic en;

	logic vld_s1, vld_s2, vld_s3, vld_s4, vld_s5, vld_s6, vld_s7;
	logic vld_s8, vld_s9, vld_s10, vld_s11, vld_s12, vld_s13;
	logic err_s2, err_s3, err_s4, err_s5, err_s6, err_s7;
	logic err_s8, err_s9, err_s10, err_s11, err_s12, err_s13;

	logic signed [39:0] t_s1;
	logic [37:0] sec_s2, sec_s3;
	logic [21:0] qd_s3;
	logic [21:0] days_s4, days_s5, d1_s5;
	logic [16:0] secday_s4, secday_s5;
	logic [4:0]  q400_s5;
	logic [19:0] q7_s5;
	logic [10:0] mt_s5, mt_s6, mt_s7;
	logic [17:0] r400_s6, r400_s7;
	logic [2:0]  wday_s6, wday_s7;
	logic [5:0]  sec_s6, sec_s7;
	logic [13:0] yoff_s6, yoff_s7, yoff_s8, yoff_s9, yoff_s10, yoff_s11;
	logic [2:0]  c100_s7;
	logic [4:0]  hour_s7;
	logic [15:0] r100_s8, r100_s9;
	tod_t        tod_s8, tod_s9, tod_s10, tod_s11, tod_s12, tod_s13;
	logic        cen3_s8, cen3_s9, cen3_s10, cen3_s11;
	logic [5:0]  q4_s9;
	logic [10:0] r4_s10, r4_s11;
	logic        q4top_s10, q4top_s11;
	logic [2:0]  y1_s11;
	logic [8:0]  yday_s12, yday_s13;
	logic [13:0] year_s12, year_s13;
	logic        leap_s12, leap_s13;
	logic [3:0]  month_s13;

	logic [62:0] day_prod;
	logic [30:0] qd_mul;
	logic [30:0] rem_day;
	logic [44:0] p400, p7;
	logic [34:0] p60;
	logic [21:0] d1;
	logic [21:0] m400, m7;
	logic [16:0] m60;
	logic [36:0] p100;
	logic [22:0] phr;
	logic [1:0]  c100c;
	logic [17:0] m100;
	logic [10:0] mhr;
	logic [32:0] p4;
	logic [4:0]  q4c;
	logic [15:0] m4;
	logic [22:0] p1;
	logic [1:0]  y1c;
	logic [10:0] m1;
	logic [3:0]  month_c;
	logic [8:0]  base_c;
	date_word_t  pipe_word;
	logic        pipe_out_vld;

	logic       out_vld_q, skid_vld_q;
	date_word_t date_q, skid_q;

	assign zone_ready = 1'b1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			zone_offset_q <= '0;
		end else if (zone_valid) begin
			zone_offset_q <= zone_offset_seconds;
		end
	end

	assign en         = !skid_vld_q;
	assign time_stall = skid_vld_q;

	assign day_prod = {32'd0, sec_s2[37:7]} * {31'd0, RCP_DAY};
	assign qd_mul   = {9'd0, qd_s3} * {21'd0, DAY_ODD};
	assign rem_day  = sec_s3[37:7] - qd_mul;

	assign d1   = days_s4 + 22'd1;
	assign p400 = {23'd0, days_s4} * {22'd0, RCP_400Y};
	assign p7   = {23'd0, d1} * {22'd0, RCP_WEEK};
	assign p60  = {18'd0, secday_s4} * {17'd0, RCP_60_SEC};

	assign m400 = {17'd0, q400_s5} * {4'd0, DAYS_400Y};
	assign m7   = {2'd0, q7_s5} * {19'd0, WEEK_LEN};
	assign m60  = {6'd0, mt_s5} * {11'd0, SIXTY};

	assign p100 = {19'd0, r400_s6} * {18'd0, RCP_100Y};
	assign phr  = {12'd0, mt_s6} * {11'd0, RCP_60_MIN};

	assign c100c = (c100_s7 > CENT_MAX) ? CENT_MAX[1:0] : c100_s7[1:0];
	assign m100  = {16'd0, c100c} * {2'd0, DAYS_100Y};
	assign mhr   = {6'd0, hour_s7} * {5'd0, SIXTY};

	assign p4 = {17'd0, r100_s8} * {16'd0, RCP_4Y};

	assign q4c = (q4_s9 > QUAD_MAX) ? QUAD_MAX[4:0] : q4_s9[4:0];
	assign m4  = {11'd0, q4c} * {5'd0, DAYS_4Y};

	assign p1 = {12'd0, r4_s10} * {11'd0, RCP_1Y};

	assign y1c = (y1_s11 > YEAR_MAX) ? YEAR_MAX[1:0] : y1_s11[1:0];
	assign m1  = {9'd0, y1c} * {2'd0, DAYS_1Y};

	always_comb begin
		month_c = 4'd11;
		for (int j = 10; j >= 0; j--) begin
			if (yday_s12 < cum_days(leap_s12, 4'(j + 1))) begin
				month_c = 4'(j);
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_s1  <= 1'b0;
			vld_s2  <= 1'b0;
			vld_s3  <= 1'b0;
			vld_s4  <= 1'b0;
			vld_s5  <= 1'b0;
			vld_s6  <= 1'b0;
			vld_s7  <= 1'b0;
			vld_s8  <= 1'b0;
			vld_s9  <= 1'b0;
			vld_s10 <= 1'b0;
			vld_s11 <= 1'b0;
			vld_s12 <= 1'b0;
			vld_s13 <= 1'b0;
		end else if (en) begin
			vld_s1  <= time_valid;
			vld_s2  <= vld_s1;
			vld_s3  <= vld_s2;
			vld_s4  <= vld_s3;
			vld_s5  <= vld_s4;
			vld_s6  <= vld_s5;
			vld_s7  <= vld_s6;
			vld_s8  <= vld_s7;
			vld_s9  <= vld_s8;
			vld_s10 <= vld_s9;
			vld_s11 <= vld_s10;
			vld_s12 <= vld_s11;
			vld_s13 <= vld_s12;
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			// apply zone offset
			t_s1 <= {time_word.epoch_seconds[38], time_word.epoch_seconds} -
				(time_word.use_local ? {{22{zone_offset_q[17]}}, zone_offset_q} : 40'd0);

			// rebase to 1601, flag range
			err_s2 <= (t_s1 < -SECS_1601_TO_1970) || (t_s1 > SECS_LAST_1970);
			sec_s2 <= 38'(t_s1 + SECS_1601_TO_1970);

			// split into days and seconds of day
			err_s3 <= err_s2;
			sec_s3 <= sec_s2;
			qd_s3  <= day_prod[62:41];

			err_s4    <= err_s3;
			days_s4   <= qd_s3;
			secday_s4 <= {rem_day[9:0], sec_s3[6:0]};

			err_s5    <= err_s4;
			q400_s5   <= p400[44:40];
			q7_s5     <= p7[44:25];
			d1_s5     <= d1;
			mt_s5     <= p60[33:23];
			days_s5   <= days_s4;
			secday_s5 <= secday_s4;

			err_s6  <= err_s5;
			r400_s6 <= 18'(days_s5 - m400);
			wday_s6 <= 3'(d1_s5 - m7);
			sec_s6  <= 6'(secday_s5 - m60);
			mt_s6   <= mt_s5;
			yoff_s6 <= {9'd0, q400_s5} * 14'd400;

			err_s7  <= err_s6;
			c100_s7 <= p100[36:34];
			hour_s7 <= phr[21:17];
			r400_s7 <= r400_s6;
			wday_s7 <= wday_s6;
			sec_s7  <= sec_s6;
			mt_s7   <= mt_s6;
			yoff_s7 <= yoff_s6;

			// cap century, finish time of day
			err_s8         <= err_s7;
			r100_s8        <= 16'(r400_s7 - m100);
			tod_s8.hour    <= hour_s7;
			tod_s8.minute  <= 6'(mt_s7 - mhr);
			tod_s8.second  <= sec_s7;
			tod_s8.wday    <= wday_s7;
			yoff_s8        <= yoff_s7 + {12'd0, c100c} * 14'd100;
			cen3_s8        <= (c100c == CENT_MAX[1:0]);

			err_s9  <= err_s8;
			q4_s9   <= p4[32:27];
			r100_s9 <= r100_s8;
			tod_s9  <= tod_s8;
			yoff_s9 <= yoff_s8;
			cen3_s9 <= cen3_s8;

			// cap quad
			err_s10   <= err_s9;
			r4_s10    <= 11'(r100_s9 - m4);
			q4top_s10 <= (q4c == QUAD_MAX[4:0]);
			tod_s10   <= tod_s9;
			yoff_s10  <= yoff_s9 + {7'd0, q4c, 2'b00};
			cen3_s10  <= cen3_s9;

			err_s11   <= err_s10;
			y1_s11    <= p1[22:20];
			r4_s11    <= r4_s10;
			q4top_s11 <= q4top_s10;
			tod_s11   <= tod_s10;
			yoff_s11  <= yoff_s10;
			cen3_s11  <= cen3_s10;

			// cap year, form year and leap flag
			err_s12  <= err_s11;
			yday_s12 <= 9'(r4_s11 - m1);
			year_s12 <= YEAR_BASE + yoff_s11 + {12'd0, y1c};
			leap_s12 <= (y1c == YEAR_MAX[1:0]) && (!q4top_s11 || cen3_s11);
			tod_s12  <= tod_s11;

			err_s13   <= err_s12;
			month_s13 <= month_c;
			yday_s13  <= yday_s12;
			year_s13  <= year_s12;
			leap_s13  <= leap_s12;
			tod_s13   <= tod_s12;
		end
	end

	assign base_c = cum_days(leap_s13, month_s13);

	always_comb begin
		pipe_word = '0;
		pipe_word.range_error = err_s13;
		if (!err_s13) begin
			pipe_word.calendar_year    = year_s13;
			pipe_word.day_of_year      = yday_s13;
			pipe_word.month_index      = month_s13;
			pipe_word.day_of_month     = 5'(yday_s13 - base_c + 9'd1);
			pipe_word.weekday          = tod_s13.wday;
			pipe_word.hour_of_day      = tod_s13.hour;
			pipe_word.minute_of_hour   = tod_s13.minute;
			pipe_word.second_of_minute = tod_s13.second;
		end
	end

	assign pipe_out_vld = vld_s13 && en;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_vld_q  <= 1'b0;
			skid_vld_q <= 1'b0;
		end else if (!out_vld_q || !date_stall) begin
			if (skid_vld_q) begin
				out_vld_q  <= 1'b1;
				skid_vld_q <= 1'b0;
			end else begin
				out_vld_q <= pipe_out_vld;
			end
		end else if (pipe_out_vld) begin
			skid_vld_q <= 1'b1;
		end
	end

	always_ff @(posedge clk) begin
		if (!out_vld_q || !date_stall) begin
			date_q <= skid_vld_q ? skid_q : pipe_word;
		end else if (pipe_out_vld) begin
			skid_q <= pipe_word;
		end
	end

	assign date_valid = out_vld_q;
	assign date_word  = date_q;

	a_skid_behind_out: assert property (@(posedge clk) disable iff (!arst_n)
		skid_vld_q |-> out_vld_q)
		else $error("skid word held without output word");

	a_error_zero: assert property (@(posedge clk) disable iff (!arst_n)
		(date_valid && date_word.range_error) |->
		(date_word.calendar_year == 14'd0 && date_word.day_of_year == 9'd0 &&
		 date_word.month_index == 4'd0 && date_word.day_of_month == 5'd0 &&
		 date_word.weekday == 3'd0 && date_word.hour_of_day == 5'd0 &&
		 date_word.minute_of_hour == 6'd0 && date_word.second_of_minute == 6'd0))
		else $error("range error word with nonzero fields");

	a_date_sane: assert property (@(posedge clk) disable iff (!arst_n)
		(date_valid && !date_word.range_error) |->
		(date_word.calendar_year >= 14'd1601 && date_word.calendar_year <= 14'd9999 &&
		 date_word.month_index <= 4'd11 && date_word.day_of_month >= 5'd1 &&
		 date_word.weekday <= 3'd6 && date_word.hour_of_day <= 5'd23 &&
		 date_word.minute_of_hour <= 6'd59 && date_word.second_of_minute <= 6'd59))
		else $error("date word field out of range");

endmodule

@@ tb/sv/testbench.sv @@
// Self-checking testbench for epoch_to_calendar_date_core: drives time words,
// predicts each calendar date word and compares it field by field.
// Depends on epcal_pkg and the core RTL.
`timescale 1ns / 100ps

module testbench;
	import epcal_pkg::*;

	localparam longint EPOCH_BIAS = 64'sd11644473600;
	localparam longint LAST_SEC   = 64'sd253402300799;
	localparam longint SPAN       = LAST_SEC + EPOCH_BIAS + 1;
	localparam longint S400       = 64'sd12622780800;
	localparam longint S100       = 64'sd3155673600;
	localparam longint S4         = 64'sd126230400;
	localparam longint SYEAR      = 64'sd31536000;
	localparam longint SDAY       = 64'sd86400;
	localparam int     PHASES     = 6;
	localparam int     RANDOM_PER_PHASE = 305;

	logic                clk = 1'b0;
	logic                arst_n = 1'b0;
	logic                time_valid = 1'b0;
	logic                time_stall;
	time_word_t          time_word = '0;
	logic                date_valid;
	logic                date_stall = 1'b0;
	date_word_t          date_word;
	logic                zone_valid = 1'b0;
	logic                zone_ready;
	logic signed [17:0]  zone_offset_seconds = '0;

	logic signed [17:0]  zone_now = '0;
	time_word_t          pending_times [$];
	date_word_t          expected_dates [$];
	int                  tx_idle_pct = 0;
	int                  rx_idle_pct = 0;
	int                  mismatches = 0;

	int month_start [12] = '{0, 31, 59, 90, 120, 151, 181, 212, 243, 273, 304, 334};

	longint edge_secs [17] = '{
		-EPOCH_BIAS, -EPOCH_BIAS - 1, LAST_SEC, LAST_SEC + 1,
		-64'sd274877906944, 64'sd274877906943, 64'sd0,
		64'sd951782400, -64'sd2203891200,
		-EPOCH_BIAS + S400 - 1, -EPOCH_BIAS + S400,
		-EPOCH_BIAS + S100 - 1, -EPOCH_BIAS + S100,
		-EPOCH_BIAS + S4 - 1, -EPOCH_BIAS + S4,
		-EPOCH_BIAS + SYEAR - 1, -EPOCH_BIAS + 4 * S400 - 1};

	epoch_to_calendar_date_core dut (
		.clk                 (clk),
		.arst_n              (arst_n),
		.time_valid          (time_valid),
		.time_stall          (time_stall),
		.time_word           (time_word),
		.date_valid          (date_valid),
		.date_stall          (date_stall),
		.date_word           (date_word),
		.zone_valid          (zone_valid),
		.zone_ready          (zone_ready),
		.zone_offset_seconds (zone_offset_seconds)
	);

	always #5 clk = ~clk;

	function automatic date_word_t calendar_of(input time_word_t w,
			input logic signed [17:0] zone);
		date_word_t d;
		longint t, secs, days, q400, c100, q4, y1, yr, yday;
		int mon, first, j;
		bit leap;
		d = '0;
		t = {{25{w.epoch_seconds[38]}}, w.epoch_seconds};
		if (w.use_local)
			t = t - longint'({{46{zone[17]}}, zone});
		if (t < -EPOCH_BIAS || t > LAST_SEC) begin
			d.range_error = 1'b1;
			return d;
		end
		secs = t + EPOCH_BIAS;
		days = secs / SDAY;
		q400 = secs / S400;
		secs = secs % S400;
		c100 = secs / S100;
		if (c100 > 3)
			c100 = 3;
		secs = secs - c100 * S100;
		q4 = secs / S4;
		if (q4 > 24)
			q4 = 24;
		secs = secs - q4 * S4;
		y1 = secs / SYEAR;
		if (y1 > 3)
			y1 = 3;
		secs = secs - y1 * SYEAR;
		yr = 1601 + q400 * 400 + c100 * 100 + q4 * 4 + y1;
		yday = secs / SDAY;
		secs = secs % SDAY;
		leap = (yr % 4 == 0 && yr % 100 != 0) || (yr % 400 == 0);
		mon = 0;
		first = 0;
		for (j = 1; j < 12; j++) begin
			if (yday >= month_start[j] + ((leap && j >= 2) ? 1 : 0)) begin
				mon = j;
				first = month_start[j] + ((leap && j >= 2) ? 1 : 0);
			end
		end
		d.calendar_year    = yr[13:0];
		d.day_of_year      = yday[8:0];
		d.month_index      = mon[3:0];
		d.day_of_month     = 5'(yday - first + 1);
		d.weekday          = 3'((days + 1) % 7);
		d.hour_of_day      = 5'(secs / 3600);
		d.minute_of_hour   = 6'((secs % 3600) / 60);
		d.second_of_minute = 6'(secs % 60);
		return d;
	endfunction

	function automatic time_word_t random_time();
		time_word_t w;
		logic [63:0] r;
		longint v, unit;
		int pick;
		r = {$urandom, $urandom};
		pick = $urandom_range(0, 99);
		if (pick < 60) begin
			v = longint'(r % SPAN) - EPOCH_BIAS;
		end else if (pick < 75) begin
			case ($urandom_range(0, 4))
				0: unit = S400;
				1: unit = S100;
				2: unit = S4;
				3: unit = SYEAR;
				default: unit = SDAY;
			endcase
			v = -EPOCH_BIAS + unit * longint'($urandom_range(0, 32'(SPAN / unit)))
				+ longint'($urandom_range(0, 345600)) - 172800;
		end else if (pick < 90) begin
			v = (r[0] ? LAST_SEC : -EPOCH_BIAS) + longint'($urandom_range(0, 400000))
				- 200000;
		end else begin
			v = longint'(r);
		end
		w.epoch_seconds = v[38:0];
		w.use_local = 1'($urandom_range(0, 1));
		return w;
	endfunction

	task automatic check_field(input string name, input longint want, input longint got);
		if (want != got) begin
			$error("%s: expected %0d, got %0d", name, want, got);
			mismatches++;
		end
	endtask

	task automatic compare_date(input date_word_t want, input date_word_t got);
		check_field("calendar_year", want.calendar_year, got.calendar_year);
		check_field("day_of_year", want.day_of_year, got.day_of_year);
		check_field("month_index", want.month_index, got.month_index);
		check_field("day_of_month", want.day_of_month, got.day_of_month);
		check_field("weekday", want.weekday, got.weekday);
		check_field("hour_of_day", want.hour_of_day, got.hour_of_day);
		check_field("minute_of_hour", want.minute_of_hour, got.minute_of_hour);
		check_field("second_of_minute", want.second_of_minute, got.second_of_minute);
		check_field("range_error", want.range_error, got.range_error);
	endtask

	task automatic write_zone(input logic signed [17:0] value);
		@(posedge clk);
		zone_valid <= 1'b1;
		zone_offset_seconds <= value;
		do @(posedge clk); while (!zone_ready);
		zone_now = value;
		zone_valid <= 1'b0;
		@(negedge clk);
	endtask

	task automatic wait_drained();
		do @(negedge clk);
		while (pending_times.size() != 0 || time_valid || expected_dates.size() != 0);
	endtask

	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			time_valid <= 1'b0;
			time_word <= '0;
		end else if (time_valid && time_stall) begin
			// hold
		end else begin
			if (time_valid)
				expected_dates.push_back(calendar_of(time_word, zone_now));
			if (pending_times.size() != 0 && $urandom_range(0, 99) >= tx_idle_pct) begin
				time_word <= pending_times.pop_front();
				time_valid <= 1'b1;
			end else begin
				time_valid <= 1'b0;
			end
		end
	end

	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			date_stall <= 1'b0;
		end else begin
			if (date_valid && !date_stall) begin
				if (expected_dates.size() == 0) begin
					$error("date word with nothing expected");
					mismatches++;
				end else begin
					compare_date(expected_dates.pop_front(), date_word);
				end
			end
			date_stall <= ($urandom_range(0, 99) < rx_idle_pct);
		end
	end

	initial begin : stimulus
		time_word_t w;
		int p, n;
		repeat (3) @(posedge clk);
		arst_n <= 1'b1;
		@(negedge clk);
		for (p = 0; p < PHASES; p++) begin
			tx_idle_pct = (p < 2) ? 8 : (p < 4) ? 83 : 0;
			rx_idle_pct = (p < 2) ? 83 : (p < 4) ? 8 : 0;
			case (p)
				1: write_zone(-18'sd86400);
				2: write_zone(18'sd86400);
				3: write_zone(-18'sd131072);
				4: write_zone(18'sd131071);
				5: write_zone(18'($urandom_range(0, 262143)));
				default: ;
			endcase
			if (p == 0) begin
				for (n = 0; n < 17; n++) begin
					w.epoch_seconds = edge_secs[n][38:0];
					w.use_local = n[0];
					pending_times.push_back(w);
				end
			end
			for (n = 0; n < RANDOM_PER_PHASE; n++)
				pending_times.push_back(random_time());
			wait_drained();
		end
		repeat (30) @(negedge clk);
		if (mismatches == 0 && expected_dates.size() == 0)
			$display("end of test: clean");
		else
			$display("end of test: mismatches");
		$finish;
	end

	initial begin
		#5000000;
		$display("end of test: mismatches");
		$finish;
	end

endmodule
